### rtl/cep_pkg.sv
// Package: shared constants, cell control struct and saturation helpers.
`timescale 1ns / 1ps
package cep_pkg;

    localparam int MAX_REGRESSORS_DEF = 16;
    localparam int MAX_CONTRASTS_DEF  = 8;
    localparam int ADDR_MAX_W         = 6;
    localparam int CON_IDX_W          = 3;

    localparam logic [1:0] OP_WEIGHT   = 2'd0;
    localparam logic [1:0] OP_ESTIMATE = 2'd1;
    localparam logic [1:0] OP_COVAR    = 2'd2;
    localparam logic [1:0] OP_END      = 2'd3;

    localparam logic [0:0] REG_REGRESSORS = 1'b0;
    localparam logic [0:0] REG_CONTRASTS  = 1'b1;

    typedef struct packed {
        logic                  wr_en;
        logic [CON_IDX_W-1:0]  wr_col;
        logic [ADDR_MAX_W-1:0] addr;
        logic                  acc_eff;
        logic                  load_t;
        logic                  load_wj;
        logic                  ring;
        logic                  clear;
        logic [3:0]            nc;
        logic [CON_IDX_W-1:0]  sel;
    } t_cell_ctl;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        lo = -64'sd2147483648;
        hi = 64'sd2147483647;
        if (v > hi) begin
            return 32'sh7fffffff;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s;
    endfunction

endpackage

### rtl/cep_in_if.sv
// Interface: input word channel.
`timescale 1ns / 1ps
interface cep_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [3:0]         first_index;
    logic [3:0]         second_index;
    logic signed [31:0] value;
    logic               present;

    modport source (output valid, op, first_index, second_index, value, present,
                    input ready);
    modport sink (input valid, op, first_index, second_index, value, present,
                  output ready);
endinterface

### rtl/cep_out_if.sv
// Interface: result word channel.
`timescale 1ns / 1ps
interface cep_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         contrast_row;
    logic [2:0]         contrast_col;
    logic signed [31:0] effect;
    logic signed [31:0] variance;
    logic               last;

    modport source (output valid, contrast_row, contrast_col, effect, variance, last,
                    input ready);
    modport sink (input valid, contrast_row, contrast_col, effect, variance, last,
                  output ready);
endinterface

### rtl/cep_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module cep_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                          i_wdata,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### rtl/cep_cell.sv
// Contrast cell: one weight column, its effect and variance accumulators, ring stage.
`timescale 1ns / 1ps
module cep_cell #(
    parameter int MAX_REGRESSORS = cep_pkg::MAX_REGRESSORS_DEF,
    parameter int MAX_CONTRASTS  = cep_pkg::MAX_CONTRASTS_DEF,
    parameter int CIDX           = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cep_pkg::t_cell_ctl                i_ctl,
    input  logic signed [31:0]                i_value,
    input  logic signed [31:0]                i_t,
    input  logic [cep_pkg::CON_IDX_W-1:0]     i_tag,
    output logic signed [31:0]                o_t,
    output logic [cep_pkg::CON_IDX_W-1:0]     o_tag,
    output logic signed [63:0]                o_eff,
    output logic signed [63:0]                o_var
);
    import cep_pkg::*;

    localparam int AW = (MAX_REGRESSORS > 1) ? $clog2(MAX_REGRESSORS) : 1;
    localparam int CW = (MAX_CONTRASTS > 1) ? $clog2(MAX_CONTRASTS) : 1;

    logic [AW-1:0]            w_addr;
    logic [31:0]              w_rd;
    logic signed [31:0]       w_w;
    logic                     w_we;
    logic                     w_live;
    logic signed [31:0]       w_ma;
    logic signed [31:0]       w_mb;

    logic [MAX_REGRESSORS-1:0] r_valid;
    logic                      r_rvld;
    logic signed [63:0]        r_prod;
    logic                      r_pv;
    logic [CON_IDX_W-1:0]      r_ptag;
    logic signed [31:0]        r_t;
    logic [CON_IDX_W-1:0]      r_tag;
    logic signed [31:0]        r_wj;
    logic signed [63:0]        r_eacc;
    logic signed [63:0]        r_vacc [MAX_CONTRASTS];

    assign w_addr = AW'(i_ctl.addr);
    assign w_we   = i_ctl.wr_en && (i_ctl.wr_col == CON_IDX_W'(CIDX));
    assign w_w    = r_rvld ? $signed(w_rd) : 32'sd0;
    assign w_live = 32'(CIDX) < 32'(i_ctl.nc);
    assign w_ma   = i_ctl.ring ? r_t : w_w;
    assign w_mb   = i_ctl.ring ? r_wj : i_value;

    cep_ram #(.WIDTH(32), .DEPTH(MAX_REGRESSORS)) u_col (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (i_value),
        .o_rdata (w_rd)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        r_ptag <= r_tag;
        r_rvld <= r_valid[w_addr] || (w_we && 1'b0);
        if (i_ctl.load_wj) begin
            r_wj <= w_w;
        end
        if (i_ctl.load_t) begin
            r_t   <= sat32(r_prod >>> 16);
            r_tag <= CON_IDX_W'(CIDX);
        end else if (i_ctl.ring) begin
            r_t   <= i_t;
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_pv    <= 1'b0;
            r_eacc  <= '0;
            for (int k = 0; k < MAX_CONTRASTS; k++) begin
                r_vacc[k] <= '0;
            end
        end else begin
            r_pv <= i_ctl.ring;
            if (w_we) begin
                r_valid[w_addr] <= 1'b1;
            end
            if (i_ctl.clear) begin
                r_eacc <= '0;
                for (int k = 0; k < MAX_CONTRASTS; k++) begin
                    r_vacc[k] <= '0;
                end
            end else begin
                if (i_ctl.acc_eff && w_live) begin
                    r_eacc <= sat_add64(r_eacc, r_prod);
                end
                if (r_pv && w_live && (32'(r_ptag) < 32'(i_ctl.nc))) begin
                    r_vacc[CW'(r_ptag)] <= sat_add64(r_vacc[CW'(r_ptag)], r_prod);
                end
            end
        end
    end

    assign o_t   = r_t;
    assign o_tag = r_tag;
    assign o_eff = r_eacc;
    assign o_var = r_vacc[CW'(i_ctl.sel)];
endmodule

### rtl/contrast_effect_projection.sv
// Top level: sequencer, configuration registers, ring of contrast cells, result stage.
//
//  channel  | dir | fields
//  i_in     | in  | op, first_index, second_index, value, present
//  o_out    | out | contrast_row, contrast_col, effect, variance, last
//  i_cfg_*  | in  | we, index, data (regressor_count, contrast_count)
//
// Weight load: accept, S_WRITE. Estimate: accept, S_READ, S_MULT, S_ACC.
// Ignored word: accept only. Covariance: accept, S_READ, S_MULT, S_ACC,
// S_READJ, S_LOADJ, S_RING (ring pass of t values through the cells, one
// multiply-accumulate per cell per cycle), S_DRAIN. End of voxel: accept, then
// per result S_EMIT_A to S_HOLD (stalls wait there), then S_CLEAR.
// Sync active-low reset: counts to 1, weight valid bits and accumulators cleared.
`timescale 1ns / 1ps
module contrast_effect_projection #(
    parameter int MAX_REGRESSORS = cep_pkg::MAX_REGRESSORS_DEF,
    parameter int MAX_CONTRASTS  = cep_pkg::MAX_CONTRASTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cep_in_if.sink     i_in,
    cep_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_index,
    input  logic [4:0] i_cfg_data
);
    import cep_pkg::*;

    localparam int CW  = (MAX_CONTRASTS > 1) ? $clog2(MAX_CONTRASTS) : 1;
    localparam int NRW = $clog2(MAX_REGRESSORS + 1);
    localparam int NCW = $clog2(MAX_CONTRASTS + 1);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_WRITE  = 14'b00000000000010,
        S_READ   = 14'b00000000000100,
        S_MULT   = 14'b00000000001000,
        S_ACC    = 14'b00000000010000,
        S_READJ  = 14'b00000000100000,
        S_LOADJ  = 14'b00000001000000,
        S_RING   = 14'b00000010000000,
        S_DRAIN  = 14'b00000100000000,
        S_EMIT_A = 14'b00001000000000,
        S_EMIT_B = 14'b00010000000000,
        S_EMIT_C = 14'b00100000000000,
        S_HOLD   = 14'b01000000000000,
        S_CLEAR  = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    logic [4:0]         r_reg_cnt;
    logic [3:0]         r_con_cnt;
    logic [1:0]         r_op;
    logic [3:0]         r_i;
    logic [3:0]         r_j;
    logic signed [31:0] r_val;
    logic               r_present;
    logic [CW-1:0]      r_step;
    logic [CW-1:0]      r_c1;
    logic [CW-1:0]      r_c2;
    logic signed [31:0] r_effv;
    logic signed [31:0] r_vv;
    logic signed [63:0] r_vp;
    logic               r_ovalid;
    logic [2:0]         r_orow;
    logic [2:0]         r_ocol;
    logic signed [31:0] r_oeff;
    logic signed [31:0] r_ovar;
    logic               r_olast;

    logic [NRW-1:0] w_nr;
    logic [NCW-1:0] w_nc;
    logic           w_i_ok;
    logic           w_jr_ok;
    logic           w_jc_ok;
    logic           w_acc;
    logic           w_last_res;
    logic           w_c2_end;
    t_cell_ctl      w_ctl;

    logic signed [31:0]    w_t   [MAX_CONTRASTS];
    logic [CON_IDX_W-1:0]  w_tag [MAX_CONTRASTS];
    logic signed [63:0]    w_eff [MAX_CONTRASTS];
    logic signed [63:0]    w_var [MAX_CONTRASTS];

    assign w_nr = (32'(r_reg_cnt) > MAX_REGRESSORS) ? NRW'(MAX_REGRESSORS) : NRW'(r_reg_cnt);
    assign w_nc = (32'(r_con_cnt) > MAX_CONTRASTS) ? NCW'(MAX_CONTRASTS) : NCW'(r_con_cnt);

    assign w_i_ok  = 32'(i_in.first_index) < 32'(w_nr);
    assign w_jr_ok = 32'(i_in.second_index) < 32'(w_nr);
    assign w_jc_ok = 32'(i_in.second_index) < 32'(w_nc);

    assign i_in.ready = (r_state == S_IDLE);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_c2_end   = 32'(r_c2) == 32'(w_nc) - 1;
    assign w_last_res = w_c2_end && (32'(r_c1) == 32'(w_nc) - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_cnt <= 5'd1;
            r_con_cnt <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_REGRESSORS: r_reg_cnt <= i_cfg_data;
                REG_CONTRASTS:  r_con_cnt <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (i_in.op)
                        OP_WEIGHT:   n_state = (w_i_ok && w_jc_ok) ? S_WRITE : S_IDLE;
                        OP_ESTIMATE: n_state = w_i_ok ? S_READ : S_IDLE;
                        OP_COVAR:    n_state = (w_i_ok && w_jr_ok) ? S_READ : S_IDLE;
                        OP_END:      n_state = (w_nc == '0) ? S_CLEAR : S_EMIT_A;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_WRITE:  n_state = S_IDLE;
            S_READ:   n_state = S_MULT;
            S_MULT:   n_state = S_ACC;
            S_ACC:    n_state = (r_op == OP_COVAR) ? S_READJ : S_IDLE;
            S_READJ:  n_state = S_LOADJ;
            S_LOADJ:  n_state = S_RING;
            S_RING:   n_state = (r_step == CW'(MAX_CONTRASTS - 1)) ? S_DRAIN : S_RING;
            S_DRAIN:  n_state = S_IDLE;
            S_EMIT_A: n_state = S_EMIT_B;
            S_EMIT_B: n_state = S_EMIT_C;
            S_EMIT_C: n_state = S_HOLD;
            S_HOLD: begin
                if (o_out.ready) begin
                    n_state = r_olast ? S_CLEAR : S_EMIT_A;
                end
            end
            S_CLEAR:  n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_step   <= '0;
            r_c1     <= '0;
            r_c2     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_RING) begin
                r_step <= r_step + CW'(1);
            end else begin
                r_step <= '0;
            end
            if (r_state == S_EMIT_C) begin
                r_ovalid <= 1'b1;
            end else if (r_state == S_HOLD && o_out.ready) begin
                r_ovalid <= 1'b0;
                if (w_c2_end) begin
                    r_c2 <= '0;
                    r_c1 <= r_c1 + CW'(1);
                end else begin
                    r_c2 <= r_c2 + CW'(1);
                end
            end
            if (r_state == S_CLEAR) begin
                r_c1 <= '0;
                r_c2 <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_op      <= i_in.op;
            r_i       <= i_in.first_index;
            r_j       <= i_in.second_index;
            r_val     <= i_in.value;
            r_present <= i_in.present;
        end
        if (r_state == S_EMIT_A) begin
            r_effv <= sat32(w_eff[r_c1] >>> 16);
            r_vv   <= sat32(w_var[r_c2] >>> 16);
        end
        if (r_state == S_EMIT_B) begin
            r_vp <= r_vv * r_val;
        end
        if (r_state == S_EMIT_C) begin
            r_orow  <= 3'(r_c1);
            r_ocol  <= 3'(r_c2);
            r_oeff  <= r_present ? r_effv : 32'sd0;
            r_ovar  <= r_present ? sat32(r_vp >>> 16) : 32'sd0;
            r_olast <= w_last_res;
        end
    end

    always_comb begin
        w_ctl         = '0;
        w_ctl.wr_en   = (r_state == S_WRITE);
        w_ctl.wr_col  = CON_IDX_W'(r_j);
        w_ctl.addr    = (r_state == S_READJ) ? ADDR_MAX_W'(r_j) : ADDR_MAX_W'(r_i);
        w_ctl.acc_eff = (r_state == S_ACC) && (r_op == OP_ESTIMATE);
        w_ctl.load_t  = (r_state == S_ACC) && (r_op == OP_COVAR);
        w_ctl.load_wj = (r_state == S_LOADJ);
        w_ctl.ring    = (r_state == S_RING);
        w_ctl.clear   = (r_state == S_CLEAR);
        w_ctl.nc      = 4'(w_nc);
        w_ctl.sel     = CON_IDX_W'(r_c1);
    end

    for (genvar g = 0; g < MAX_CONTRASTS; g++) begin : g_cell
        localparam int PREV = (g + MAX_CONTRASTS - 1) % MAX_CONTRASTS;
        cep_cell #(
            .MAX_REGRESSORS (MAX_REGRESSORS),
            .MAX_CONTRASTS  (MAX_CONTRASTS),
            .CIDX           (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_value (r_val),
            .i_t     (w_t[PREV]),
            .i_tag   (w_tag[PREV]),
            .o_t     (w_t[g]),
            .o_tag   (w_tag[g]),
            .o_eff   (w_eff[g]),
            .o_var   (w_var[g])
        );
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.contrast_row = r_orow;
    assign o_out.contrast_col = r_ocol;
    assign o_out.effect       = r_oeff;
    assign o_out.variance     = r_ovar;
    assign o_out.last         = r_olast;
endmodule
